// ===== src/ws2812_pulse_width_encoder_macros.svh =====
// Assertion macros for the single-wire LED pulse encoder.
// Used by the control and output modules; no other dependencies.
`ifndef WS2812_PULSE_WIDTH_ENCODER_MACROS_SVH
`define WS2812_PULSE_WIDTH_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WSPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define WSPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WSPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/wspe_pkg.sv =====
// Package of the single-wire LED pulse encoder: codes, register defaults, types.
// No dependencies.
`default_nettype none
package wspe_pkg;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 16;
    localparam int FB_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LEAD  = 2'd1;
    localparam logic [1:0] PH_BITS  = 2'd2;
    localparam logic [1:0] PH_PAUSE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME     = 3'd4;

    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd200;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd100;
    localparam logic [TICK_W-1:0] RST_PERIOD    = 16'd300;
    localparam logic [TICK_W-1:0] RST_PAUSE     = 16'd12000;
    localparam logic [FB_W-1:0]   RST_FRAME     = 5'd12;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic refused;
        logic done_res;
    } t_result;

    // sequencing requests from control to the frame store
    typedef struct packed {
        logic start;
        logic advance;
        logic fetch_en;
    } t_seq_ctl;

endpackage
`default_nettype wire

// ===== src/wspe_in_if.sv =====
// Input channel of the pulse encoder: command transaction with valid/ready.
// Depends on wspe_pkg.
`default_nettype none
interface wspe_in_if
    import wspe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== src/wspe_out_if.sv =====
// Output channel of the pulse encoder: result transaction with valid/ready.
// No dependencies.
`default_nettype none
interface wspe_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic refused;
    logic done_res;

    modport source (output valid, output pin_level, output busy_res, output refused,
                    output done_res, input ready);
    modport sink   (input valid, input pin_level, input busy_res, input refused,
                    input done_res, output ready);
endinterface
`default_nettype wire

// ===== src/ws2812_pulse_width_encoder.sv =====
// Top level of the single-wire LED pulse encoder.
// Depends on wspe_pkg, wspe_in_if, wspe_out_if, wspe_store, wspe_ctrl, wspe_out.
//
// Each input transaction is one command: a timer tick, a byte write into the
// frame store, or a start. Every transaction yields exactly one result, registered
// in the cycle after it is taken, and a new transaction is taken every cycle while
// the result register is empty or being drained, so one tick per clock is sustained.
// The per-item work is the phase/tick/bit update plus a 16-bit compare; the
// current byte comes from a prefetch register refilled from the store memory
// at each byte boundary. The store is cleared at reset through per-entry valid
// bits, so no clearing pass is needed. Configuration writes go through the
// plain write port and must only be issued while no transaction is in flight.
`default_nettype none
module ws2812_pulse_width_encoder
    import wspe_pkg::*;
#(
    parameter int FRAME_BYTES_MAX = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    wspe_in_if.sink                    i_in,
    wspe_out_if.source                 o_out
);

    localparam int AW = (FRAME_BYTES_MAX > 1) ? $clog2(FRAME_BYTES_MAX) : 1;

    logic              acc;
    logic              in_ready;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     fetch_addr;
    logic [BYTE_W-1:0] cur_byte;
    t_seq_ctl          seq;
    t_result           res;

    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;

    wspe_store #(
        .FRAME_BYTES_MAX (FRAME_BYTES_MAX),
        .AW              (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (i_in.data_byte),
        .i_seq        (seq),
        .i_fetch_addr (fetch_addr),
        .o_cur_byte   (cur_byte)
    );

    wspe_ctrl #(
        .FRAME_BYTES_MAX (FRAME_BYTES_MAX),
        .AW              (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_acc        (acc),
        .i_command    (i_in.command),
        .i_cur_byte   (cur_byte),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_seq        (seq),
        .o_fetch_addr (fetch_addr),
        .o_res        (res)
    );

    wspe_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_res      (res),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

// ===== src/wspe_store.sv =====
// Frame store of the pulse encoder: byte memory with valid bits, shadow copies
// of the first two entries and a one-byte prefetch. Depends on wspe_pkg.
`default_nettype none
module wspe_store
    import wspe_pkg::*;
#(
    parameter int FRAME_BYTES_MAX = 16,
    parameter int AW              = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [BYTE_W-1:0] i_wr_data,
    input  wire t_seq_ctl          i_seq,
    input  wire logic [AW-1:0]     i_fetch_addr,
    output logic [BYTE_W-1:0]      o_cur_byte
);

    localparam logic [AW-1:0] SECOND_IDX = AW'(1 % FRAME_BYTES_MAX);

    logic [BYTE_W-1:0]          r_mem [FRAME_BYTES_MAX];
    logic [FRAME_BYTES_MAX-1:0] r_vld;
    logic [BYTE_W-1:0]          r_rd;
    logic                       r_rd_vld;
    logic                       r_pend;
    logic [BYTE_W-1:0]          r_s0;
    logic [BYTE_W-1:0]          r_s1;
    logic [BYTE_W-1:0]          r_byte;
    logic [BYTE_W-1:0]          r_next;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_fetch_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_pend   <= 1'b0;
            r_s0     <= '0;
            r_s1     <= '0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
                if (i_wr_addr == '0) begin
                    r_s0 <= i_wr_data;
                end
                if (i_wr_addr == SECOND_IDX) begin
                    r_s1 <= i_wr_data;
                end
            end
            r_rd_vld <= r_vld[i_fetch_addr];
            r_pend   <= i_seq.advance & i_seq.fetch_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq.start) begin
            r_byte <= r_s0;
            r_next <= r_s1;
        end else if (i_seq.advance) begin
            r_byte <= r_next;
        end else if (r_pend) begin
            r_next <= r_rd_vld ? r_rd : '0;
        end
    end

    assign o_cur_byte = r_byte;

endmodule
`default_nettype wire

// ===== src/wspe_ctrl.sv =====
// Control of the pulse encoder: configuration registers, phase sequencer, tick
// and bit counters, result computation. Depends on wspe_pkg and the macro header.
`default_nettype none
`include "ws2812_pulse_width_encoder_macros.svh"
module wspe_ctrl
    import wspe_pkg::*;
#(
    parameter int FRAME_BYTES_MAX = 16,
    parameter int AW              = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_acc,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [BYTE_W-1:0]     i_cur_byte,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output t_seq_ctl                   o_seq,
    output logic [AW-1:0]              o_fetch_addr,
    output t_result                    o_res
);

    localparam int PW  = $clog2(FRAME_BYTES_MAX + 1);
    localparam int BPW = PW + 3;
    localparam int CW  = (PW > FB_W) ? PW : FB_W;
    localparam logic [PW-1:0] MAX_P  = PW'(FRAME_BYTES_MAX);
    localparam logic [CW-1:0] MAX_C  = CW'(FRAME_BYTES_MAX);
    localparam logic [PW:0]   MAX_P1 = (PW + 1)'(FRAME_BYTES_MAX);

    logic [TICK_W-1:0] r_one_high;
    logic [TICK_W-1:0] r_zero_high;
    logic [TICK_W-1:0] r_period;
    logic [TICK_W-1:0] r_pause;
    logic [FB_W-1:0]   r_frame_bytes;

    logic [1:0]        r_phase,  n_phase;
    logic [TICK_W-1:0] r_tick,   n_tick;
    logic [BPW-1:0]    r_bitpos, n_bitpos;
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;

    logic              idle;
    logic [TICK_W-1:0] period_eff;
    logic [TICK_W-1:0] pause_eff;
    logic [CW-1:0]     fb_clamp;
    logic [BPW-1:0]    total_bits;
    logic [TICK_W:0]   tick_inc;
    logic [BPW-1:0]    bitpos_inc;
    logic [PW:0]       next_idx;
    logic [TICK_W-1:0] high_ticks;
    logic              cur_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high    <= RST_ONE_HIGH;
            r_zero_high   <= RST_ZERO_HIGH;
            r_period      <= RST_PERIOD;
            r_pause       <= RST_PAUSE;
            r_frame_bytes <= RST_FRAME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ONE_HIGH: begin
                    r_one_high <= i_cfg_wdata;
                end
                CFG_ZERO_HIGH: begin
                    r_zero_high <= i_cfg_wdata;
                end
                CFG_PERIOD: begin
                    r_period <= i_cfg_wdata;
                end
                CFG_PAUSE: begin
                    r_pause <= i_cfg_wdata;
                end
                CFG_FRAME: begin
                    r_frame_bytes <= i_cfg_wdata[FB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign idle       = (r_phase == PH_IDLE);
    assign period_eff = (r_period == '0) ? TICK_W'(1) : r_period;
    assign pause_eff  = (r_pause == '0) ? TICK_W'(1) : r_pause;
    assign fb_clamp   = (CW'(r_frame_bytes) > MAX_C) ? MAX_C : CW'(r_frame_bytes);
    assign total_bits = {PW'(fb_clamp), 3'b000};
    assign tick_inc   = {1'b0, r_tick} + (TICK_W + 1)'(1);
    assign bitpos_inc = r_bitpos + BPW'(1);
    assign next_idx   = {1'b0, bitpos_inc[BPW-1:3]} + (PW + 1)'(1);
    assign cur_bit    = i_cur_byte[~r_bitpos[2:0]];
    assign high_ticks = cur_bit ? r_one_high : r_zero_high;

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bitpos     = r_bitpos;
        n_wr_ptr     = r_wr_ptr;
        o_res        = '0;
        o_seq        = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_wr_ptr[AW-1:0];
        o_fetch_addr = next_idx[AW-1:0];
        if (i_acc) begin
            case (i_command)
                CMD_WRITE: begin
                    o_res.busy_res = !idle;
                    if (!idle || r_wr_ptr >= MAX_P) begin
                        o_res.refused = 1'b1;
                    end else begin
                        o_wr_en  = 1'b1;
                        n_wr_ptr = r_wr_ptr + PW'(1);
                    end
                end
                CMD_START: begin
                    o_res.busy_res = 1'b1;
                    if (!idle) begin
                        o_res.refused = 1'b1;
                    end else begin
                        n_phase     = PH_LEAD;
                        n_tick      = '0;
                        n_bitpos    = '0;
                        n_wr_ptr    = '0;
                        o_seq.start = 1'b1;
                    end
                end
                CMD_TICK: begin
                    o_res.busy_res = !idle;
                    case (r_phase)
                        PH_LEAD: begin
                            n_tick = tick_inc[TICK_W-1:0];
                            if (tick_inc >= {1'b0, period_eff}) begin
                                n_tick  = '0;
                                n_phase = (total_bits != '0) ? PH_BITS : PH_PAUSE;
                            end
                        end
                        PH_BITS: begin
                            o_res.pin_level = (r_tick < high_ticks);
                            n_tick = tick_inc[TICK_W-1:0];
                            if (tick_inc >= {1'b0, period_eff}) begin
                                n_tick   = '0;
                                n_bitpos = bitpos_inc;
                                if (bitpos_inc >= total_bits) begin
                                    n_phase = PH_PAUSE;
                                end else if (bitpos_inc[2:0] == 3'b000) begin
                                    o_seq.advance  = 1'b1;
                                    o_seq.fetch_en = (next_idx < MAX_P1);
                                end
                            end
                        end
                        PH_PAUSE: begin
                            n_tick = tick_inc[TICK_W-1:0];
                            if (tick_inc >= {1'b0, pause_eff}) begin
                                n_tick         = '0;
                                n_phase        = PH_IDLE;
                                o_res.done_res = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    o_res.busy_res = !idle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bitpos <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bitpos <= n_bitpos;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    logic start_ok;
    logic write_busy;
    assign start_ok   = i_acc && (i_command == CMD_START) && idle;
    assign write_busy = i_acc && (i_command == CMD_WRITE) && !idle;

    `WSPE_ASSERT_IMP(a_idle_tick_clear, i_clk, i_rst_n, idle, r_tick == '0, "tick count set while idle")
    `WSPE_ASSERT_NXT(a_start_lead, i_clk, i_rst_n, start_ok, (r_phase == PH_LEAD) && (r_wr_ptr == '0), "start did not enter lead-in")
    `WSPE_ASSERT_NXT(a_busy_write_held, i_clk, i_rst_n, write_busy, $stable(r_wr_ptr), "refused write moved pointer")

endmodule
`default_nettype wire

// ===== src/wspe_out.sv =====
// Result register of the pulse encoder: holds one result transaction until
// taken and derives input ready. Depends on wspe_pkg, wspe_out_if, macro header.
`default_nettype none
`include "ws2812_pulse_width_encoder_macros.svh"
module wspe_out
    import wspe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_acc,
    input  wire t_result i_res,
    output logic         o_in_ready,
    wspe_out_if.source   o_out
);

    logic    r_valid;
    t_result r_item;

    assign o_in_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_acc) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_item <= i_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.pin_level = r_item.pin_level;
    assign o_out.busy_res  = r_item.busy_res;
    assign o_out.refused   = r_item.refused;
    assign o_out.done_res  = r_item.done_res;

    `WSPE_ASSERT_NXT(a_acc_loads, i_clk, i_rst_n, i_acc, r_valid, "accepted transaction left no result")
    `WSPE_ASSERT_IMP(a_acc_has_room, i_clk, i_rst_n, i_acc, o_in_ready, "accept while result register full")
    `WSPE_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_valid && !o_out.ready, r_valid && $stable(r_item), "result changed while stalled")

endmodule
`default_nettype wire

// ===== tb/tb_ws2812_pulse_width_encoder.sv =====
// Testbench for ws2812_pulse_width_encoder: command transactions with bursty input,
// patterned output stalls, an in-order result predictor and per-field checks.
// Depends on wspe_pkg, wspe_in_if, wspe_out_if and the encoder RTL.
`timescale 1ns / 1ps
module tb_ws2812_pulse_width_encoder;
    import wspe_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int TAIL_CYCLES  = 8;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_e;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    wspe_in_if  in_ch ();
    wspe_out_if out_ch ();

    ws2812_pulse_width_encoder #(.FRAME_BYTES_MAX(STORE_DEPTH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [TICK_W-1:0] m_one_high, m_zero_high, m_period, m_pause;
    logic [FB_W-1:0]   m_frame;
    logic [BYTE_W-1:0] m_store [STORE_DEPTH];
    int unsigned       m_wr_ptr, m_bit_pos, m_ticks;
    logic [1:0]        m_phase;

    t_result     level_q [$];
    int unsigned err_cnt    = 0;
    int unsigned sent_cnt   = 0;
    int unsigned result_cnt = 0;
    int unsigned burst_left = 0;
    int unsigned hold_req   = 0;

    function automatic void model_reset();
        m_one_high  = RST_ONE_HIGH;
        m_zero_high = RST_ZERO_HIGH;
        m_period    = RST_PERIOD;
        m_pause     = RST_PAUSE;
        m_frame     = RST_FRAME;
        foreach (m_store[k]) m_store[k] = '0;
        m_wr_ptr  = 0;
        m_bit_pos = 0;
        m_ticks   = 0;
        m_phase   = PH_IDLE;
    endfunction

    function automatic t_result encode_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
        t_result     r;
        int unsigned period, pause_len, n_bits, hold;
        logic        bit_val;
        r         = '0;
        period    = (m_period == 0) ? 1 : m_period;
        pause_len = (m_pause == 0) ? 1 : m_pause;
        n_bits    = ((m_frame > STORE_DEPTH) ? STORE_DEPTH : m_frame) * 8;
        case (cmd)
            CMD_WRITE: begin
                if (m_phase != PH_IDLE || m_wr_ptr >= STORE_DEPTH) begin
                    r.refused = 1'b1;
                end else begin
                    m_store[m_wr_ptr] = data;
                    m_wr_ptr++;
                end
                r.busy_res = (m_phase != PH_IDLE);
            end
            CMD_START: begin
                if (m_phase != PH_IDLE) begin
                    r.refused = 1'b1;
                end else begin
                    m_phase   = PH_LEAD;
                    m_ticks   = 0;
                    m_bit_pos = 0;
                    m_wr_ptr  = 0;
                end
                r.busy_res = 1'b1;
            end
            CMD_NOP: r.busy_res = (m_phase != PH_IDLE);
            default: begin
                if (m_phase != PH_IDLE) begin
                    r.busy_res = 1'b1;
                    case (m_phase)
                        PH_LEAD: begin
                            m_ticks++;
                            if (m_ticks >= period) begin
                                m_ticks = 0;
                                m_phase = (n_bits > 0) ? PH_BITS : PH_PAUSE;
                            end
                        end
                        PH_BITS: begin
                            bit_val = m_store[(m_bit_pos / 8) % STORE_DEPTH][BYTE_W-1 - m_bit_pos % 8];
                            hold    = bit_val ? m_one_high : m_zero_high;
                            r.pin_level = (m_ticks < hold);
                            m_ticks++;
                            if (m_ticks >= period) begin
                                m_ticks = 0;
                                m_bit_pos++;
                                if (m_bit_pos >= n_bits) m_phase = PH_PAUSE;
                            end
                        end
                        default: begin
                            m_ticks++;
                            if (m_ticks >= pause_len) begin
                                m_ticks    = 0;
                                m_phase    = PH_IDLE;
                                r.done_res = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        string   field_name [4];
        field_name = '{"done_res", "refused", "busy_res", "pin_level"};
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.pin_level, out_ch.busy_res, out_ch.refused, out_ch.done_res};
            if (level_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with no transaction pending", result_cnt));
            end else begin
                want = level_q.pop_front();
                for (int k = 0; k < 4; k++)
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("result %0d %s: got %b expected %b",
                                                  result_cnt, field_name[k], got[k], want[k]));
            end
            result_cnt++;
        end
    end

    // output side: stall patterns plus an on-demand long hold-off
    initial begin : receiver
        int unsigned hold_left, mode_left, step;
        rx_mode_e    mode;
        out_ch.ready = 1'b0;
        hold_left    = 0;
        mode_left    = 0;
        step         = 0;
        mode         = RX_STEADY;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_e'($urandom_range(2, 0));
                mode_left = $urandom_range(256, 32);
            end
            mode_left--;
            step++;
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_STEADY: out_ch.ready <= 1'b1;
                    RX_RANDOM: out_ch.ready <= ($urandom_range(9, 0) >= 3);
                    default:   out_ch.ready <= (step % 3 == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** ws2812_pulse_width_encoder: FAILED **");
        $finish;
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
            burst_left = $urandom_range(24, 1);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_byte <= data;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        level_q.push_back(encode_command(cmd, data));
        sent_cnt++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // leaves the write enable high; callers lower it after their last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_ONE_HIGH:  m_one_high  = value;
            CFG_ZERO_HIGH: m_zero_high = value;
            CFG_PERIOD:    m_period    = value;
            CFG_PAUSE:     m_pause     = value;
            CFG_FRAME:     m_frame     = value[FB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [TICK_W-1:0] one_high, logic [TICK_W-1:0] zero_high,
                             logic [TICK_W-1:0] period, logic [TICK_W-1:0] pause_len,
                             logic [CFG_DATA_W-1:0] frame_raw);
        settle();
        write_reg(CFG_ONE_HIGH, one_high);
        write_reg(CFG_ZERO_HIGH, zero_high);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_PAUSE, pause_len);
        write_reg(CFG_FRAME, frame_raw);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_frame();
        send_item(CMD_START, $urandom_range(255, 0));
        while (m_phase != PH_IDLE) send_item(CMD_TICK, $urandom_range(255, 0));
    endtask

    task automatic test_reset_defaults();
        logic [BYTE_W-1:0] pattern [6];
        pattern = '{8'h80, 8'hFF, 8'h00, 8'h01, 8'h55, 8'hAA};
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_NOP, 8'hA5);
        foreach (pattern[k]) send_item(CMD_WRITE, pattern[k]);
        repeat (6) send_item(CMD_WRITE, $urandom_range(255, 0));
        send_item(CMD_START, 8'h00);
        send_item(CMD_START, 8'hFF);
        send_item(CMD_WRITE, 8'h3C);
        send_item(CMD_NOP, 8'h00);
        // full default lead-in, then a short remainder of the frame
        repeat (RST_PERIOD + 1) send_item(CMD_TICK, $urandom_range(255, 0));
        configure(3, 1, 4, 2, 1);
        while (m_phase != PH_IDLE) send_item(CMD_TICK, $urandom_range(255, 0));
        send_item(CMD_TICK, 8'h00);
    endtask

    task automatic test_store_limits();
        configure(1, 0, 0, 1, STORE_DEPTH);
        repeat (STORE_DEPTH + 2) send_item(CMD_WRITE, $urandom_range(255, 0));
        run_frame();
        // pointer rewinds on start, older bytes stay in the store
        repeat (2) send_item(CMD_WRITE, $urandom_range(255, 0));
        configure(1, 0, 0, 1, 3);
        run_frame();
    endtask

    task automatic test_register_corners();
        configure(1, 1, 0, 0, 0);
        run_frame();
        configure(1, 0, 1, 1, 16'hFFFF);
        run_frame();
        configure(5, 4, 5, 3, 1);
        send_item(CMD_WRITE, 8'hA5);
        run_frame();
        configure(1, 2, 2, 1, 2);
        settle();
        for (int k = CFG_FRAME + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(k[CFG_IDX_W-1:0], $urandom_range(16'hFFFF, 0));
        i_cfg_we <= 1'b0;
        run_frame();
    endtask

    task automatic test_long_timing();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_item(CMD_START, $urandom_range(255, 0));
        repeat (20) send_item(CMD_TICK, $urandom_range(255, 0));
        // shorten the lead-in underway, then the pause underway
        configure(16'hFFFF, 16'h8000, 3, 16'hFFFF, 1);
        repeat (30) send_item(CMD_TICK, $urandom_range(255, 0));
        configure(16'hFFFF, 16'h8000, 3, 2, 1);
        while (m_phase != PH_IDLE) send_item(CMD_TICK, $urandom_range(255, 0));
    endtask

    task automatic test_backpressure();
        configure(2, 1, 2, 4, 4);
        repeat (4) send_item(CMD_WRITE, $urandom_range(255, 0));
        send_item(CMD_START, 8'h00);
        hold_req = 400;
        repeat (60) send_item(CMD_TICK, $urandom_range(255, 0));
        while (m_phase != PH_IDLE) send_item(CMD_TICK, $urandom_range(255, 0));
    endtask

    task automatic test_random();
        int unsigned       first_cnt, n_writes, n_frames, fb;
        logic [CMD_W-1:0]  cmd;
        first_cnt = sent_cnt;
        while (sent_cnt - first_cnt < RANDOM_ITEMS) begin
            fb = ($urandom_range(15, 0) == 0) ? $urandom_range(31, 13) : $urandom_range(3, 0);
            configure($urandom_range(3, 0), $urandom_range(3, 0), $urandom_range(3, 0),
                      $urandom_range(4, 0), {11'($urandom()), 5'(fb)});
            n_frames = $urandom_range(3, 1);
            repeat (n_frames) begin
                n_writes = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 14)
                                                       : $urandom_range(5, 0);
                repeat (n_writes) begin
                    case ($urandom_range(5, 0))
                        0:       cmd = CMD_TICK;
                        1:       cmd = CMD_NOP;
                        default: cmd = CMD_WRITE;
                    endcase
                    send_item(cmd, $urandom_range(255, 0));
                end
                send_item(CMD_START, $urandom_range(255, 0));
                while (m_phase != PH_IDLE) begin
                    cmd = ($urandom_range(9, 0) == 0) ? CMD_W'($urandom_range(CMD_NOP, CMD_WRITE))
                                                      : CMD_TICK;
                    send_item(cmd, $urandom_range(255, 0));
                end
            end
        end
    endtask

    initial begin : main_seq
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_TICK;
        in_ch.data_byte = '0;
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_store_limits();
        test_register_corners();
        test_long_timing();
        test_backpressure();
        test_random();
        in_ch.valid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("** ws2812_pulse_width_encoder: PASSED **");
        else
            $display("** ws2812_pulse_width_encoder: FAILED **");
        $finish;
    end

endmodule
